### src/rsg_pkg.sv
// ----------------------------------------------------------------------------
// rsg_pkg
// Shared types, codes and the scramble function of the sequence generator.
// ----------------------------------------------------------------------------
package rsg_pkg;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_GEN    = 2'd1,
      OP_SEED   = 2'd2,
      OP_MIDDLE = 2'd3
   } op_type;

   // Scramble modes.
   typedef enum logic [1:0] {
      SCR_NONE  = 2'd0,
      SCR_THIRD = 2'd1,
      SCR_THUE  = 2'd2,
      SCR_GRAY  = 2'd3
   } scramble_type;

   // Configuration register indexes.
   localparam logic CSR_DIMS = 1'b0;
   localparam logic CSR_MODE = 1'b1;

   localparam logic [63:0] THIRD_PAT = 64'h5555_5555_5555_5555;
   localparam logic [63:0] THUE_PAT  = 64'h6996_9669_6996_9669;
   localparam int          SEED_BITS = 8;
   localparam logic [4:0]  DIMS_RESET = 5'd1;

   // Control part of a queued command.
   typedef struct packed {
      op_type     kind;
      logic [3:0] dim;
      logic [7:0] seed_byte;
      logic       seed_first;
   } cmd_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_GEN_STEP,
      ST_GEN_EMIT,
      ST_SEED,
      ST_MIDDLE
   } state_type;

   // Scramble the bits of a below k, the top set bit of m & ~a.
   function automatic logic [63:0] scramble64(input logic [63:0] a, input logic [63:0] m,
                                              input scramble_type mode);
      logic [63:0] smear;
      logic [63:0] low;
      logic [63:0] g;
      smear = m & ~a;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      smear = smear | (smear >> 16);
      smear = smear | (smear >> 32);
      low = smear >> 1;
      g = a & low;
      g = g ^ (g >> 1);
      g = g ^ (g >> 2);
      g = g ^ (g >> 4);
      g = g ^ (g >> 8);
      g = g ^ (g >> 16);
      g = g ^ (g >> 32);
      case (mode)
         SCR_THIRD: scramble64 = a ^ (THIRD_PAT & low);
         SCR_THUE:  scramble64 = a ^ (THUE_PAT & low);
         SCR_GRAY:  scramble64 = (a & ~low) | g;
         default:   scramble64 = a;
      endcase
   endfunction

endpackage

### src/rsg_if.sv
// ----------------------------------------------------------------------------
// rsg_req_if / rsg_rsp_if
// Valid/ready channels for command items and coordinate results.
// ----------------------------------------------------------------------------
interface rsg_req_if #(parameter int VALUE_WIDTH = 48);
   logic                   valid;
   logic                   ready;
   logic [1:0]             op;
   logic [3:0]             dim_index;
   logic [VALUE_WIDTH-1:0] step_value;
   logic [VALUE_WIDTH-1:0] modulus_value;
   logic [7:0]             seed_byte;
   logic                   seed_first;

   modport source (output valid, op, dim_index, step_value, modulus_value, seed_byte,
                   seed_first, input ready);
   modport sink (input valid, op, dim_index, step_value, modulus_value, seed_byte,
                 seed_first, output ready);
endinterface

interface rsg_rsp_if #(parameter int VALUE_WIDTH = 48);
   logic                 valid;
   logic                 ready;
   logic [3:0]           dim_out;
   logic [VALUE_WIDTH:0] point_numerator;
   logic [VALUE_WIDTH:0] point_denominator;
   logic                 last;

   modport source (output valid, dim_out, point_numerator, point_denominator, last,
                   input ready);
   modport sink (input valid, dim_out, point_numerator, point_denominator, last,
                 output ready);
endinterface

### src/rsg_front.sv
// ----------------------------------------------------------------------------
// rsg_front
// Input register: takes command items and classifies them by operation.
// ----------------------------------------------------------------------------
module rsg_front #(
   parameter int VALUE_WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   rsg_req_if.sink                  req,
   output logic                     push,
   input  logic                     push_ready,
   output rsg_pkg::cmd_type         push_cmd,
   output logic [VALUE_WIDTH-1:0]   push_step,
   output logic [VALUE_WIDTH-1:0]   push_mod
);
   import rsg_pkg::*;

   logic                   vld_ff, vld_in;
   cmd_type                cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0] step_ff, mod_ff;

   assign req.ready = !vld_ff || push_ready;

   // Classify the item by its operation code.
   always_comb begin
      cmd_in.kind       = op_type'(req.op);
      cmd_in.dim        = req.dim_index;
      cmd_in.seed_byte  = req.seed_byte;
      cmd_in.seed_first = req.seed_first;
      vld_in = (vld_ff && !push_ready) || (req.valid && req.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (req.valid && req.ready) begin
         cmd_ff  <= cmd_in;
         step_ff <= req.step_value;
         mod_ff  <= req.modulus_value;
      end
   end

   assign push      = vld_ff;
   assign push_cmd  = cmd_ff;
   assign push_step = step_ff;
   assign push_mod  = mod_ff;
endmodule

### src/rsg_queue.sv
// ----------------------------------------------------------------------------
// rsg_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rsg_queue #(
   parameter int VALUE_WIDTH = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   push_ready,
   input  rsg_pkg::cmd_type       push_cmd,
   input  logic [VALUE_WIDTH-1:0] push_step,
   input  logic [VALUE_WIDTH-1:0] push_mod,
   output logic                   pop_valid,
   input  logic                   pop,
   output rsg_pkg::cmd_type       pop_cmd,
   output logic [VALUE_WIDTH-1:0] pop_step,
   output logic [VALUE_WIDTH-1:0] pop_mod
);
   import rsg_pkg::*;

   cmd_type                cmd_ff  [2];
   logic [VALUE_WIDTH-1:0] step_ff [2];
   logic [VALUE_WIDTH-1:0] mod_ff  [2];
   logic                   wp_ff, rp_ff;
   logic [1:0]             cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Occupancy follows pushes and pops.
   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wp_ff <= !wp_ff;
         if (do_pop)  rp_ff <= !rp_ff;
      end
      if (do_push) begin
         cmd_ff[wp_ff]  <= push_cmd;
         step_ff[wp_ff] <= push_step;
         mod_ff[wp_ff]  <= push_mod;
      end
   end

   assign pop_cmd  = cmd_ff[rp_ff];
   assign pop_step = step_ff[rp_ff];
   assign pop_mod  = mod_ff[rp_ff];
endmodule

### src/rsg_back.sv
// ----------------------------------------------------------------------------
// rsg_back
// Sequencer that executes commands on the per-dimension tables.
// ----------------------------------------------------------------------------
module rsg_back #(
   parameter int MAX_DIMS    = 16,
   parameter int VALUE_WIDTH = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [4:0]             cfg_dims,
   input  rsg_pkg::scramble_type  cfg_mode,
   input  logic                   pop_valid,
   output logic                   pop,
   input  rsg_pkg::cmd_type       pop_cmd,
   input  logic [VALUE_WIDTH-1:0] pop_step,
   input  logic [VALUE_WIDTH-1:0] pop_mod,
   rsg_rsp_if.source              rsp
);
   import rsg_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int NW = $clog2(MAX_DIMS + 1);
   localparam int CW = $clog2(W + 1);

   // Per-dimension tables; the accumulator reads zero until written.
   logic [W-1:0]        step_tab [MAX_DIMS];
   logic [W-1:0]        mod_tab  [MAX_DIMS];
   logic [W-1:0]        acc_tab  [MAX_DIMS];
   logic [MAX_DIMS-1:0] acc_vld_ff;

   state_type    state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;
   logic [NW-1:0] d_ff, d_in;
   logic [DW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  sh_ff, sh_in;
   logic [W-1:0]  mod_ff, mod_in;

   logic [NW-1:0] n;
   logic [DW-1:0] rd_idx;
   logic [W-1:0]  rd_step, rd_mod, rd_acc;
   logic          acc_we, tab_we;
   logic [DW-1:0] acc_wa;
   logic [W-1:0]  acc_wd;
   logic [W:0]    sum, trial;
   logic [W-1:0]  gen_acc, scr;
   logic [DW-1:0] seed_start;
   logic [NW-1:0] pos_next;
   logic          slot_free;

   logic             out_vld_ff, out_vld_in;
   logic [3:0]       out_dim_ff;
   logic [W:0]       out_num_ff, out_den_ff;
   logic             out_last_ff;
   logic             out_load;

   // Dimensions in use, saturated to the table depth.
   assign n = (32'(cfg_dims) > MAX_DIMS) ? NW'(MAX_DIMS) : NW'(cfg_dims);

   // Seeding starts at the stored position unless restarted or past the end.
   always_comb begin
      seed_start = pop_cmd.seed_first ? '0 : pos_ff;
      if (NW'(seed_start) >= n) seed_start = '0;
   end

   assign rd_idx  = (state_ff == ST_IDLE) ? seed_start : d_ff[DW-1:0];
   assign rd_step = step_tab[rd_idx];
   assign rd_mod  = mod_tab[rd_idx];
   assign rd_acc  = acc_vld_ff[rd_idx] ? acc_tab[rd_idx] : '0;

   // One modular add for generate.
   always_comb begin
      sum = {1'b0, rd_acc} + {1'b0, rd_step};
      if (rd_mod == '0) begin
         gen_acc = '0;
      end else if (sum >= {1'b0, rd_mod}) begin
         gen_acc = W'(sum - {1'b0, rd_mod});
      end else begin
         gen_acc = W'(sum);
      end
   end

   // Shift-subtract step shared by step reduction and seeding.
   always_comb begin
      trial = {r_ff, sh_ff[W-1]};
      if (trial >= {1'b0, mod_ff}) trial = trial - {1'b0, mod_ff};
   end

   assign scr       = W'(scramble64(64'(r_ff), 64'(mod_ff), cfg_mode));
   assign slot_free = !out_vld_ff || rsp.ready;
   assign pos_next  = (NW'(d_ff) + NW'(1) >= n) ? '0 : NW'(d_ff) + NW'(1);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      d_in     = d_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      r_in     = r_ff;
      sh_in    = sh_ff;
      mod_in   = mod_ff;
      pop      = 1'b0;
      acc_we   = 1'b0;
      acc_wa   = d_ff[DW-1:0];
      acc_wd   = '0;
      tab_we   = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop    = 1'b1;
               cmd_in = pop_cmd;
               d_in   = '0;
               unique case (pop_cmd.kind)
                  OP_LOAD: begin
                     if (32'(pop_cmd.dim) < MAX_DIMS) begin
                        state_in = ST_LOAD;
                        r_in     = '0;
                        sh_in    = pop_step;
                        mod_in   = pop_mod;
                        cnt_in   = CW'(W);
                     end
                  end
                  OP_GEN: begin
                     if (n != '0) state_in = ST_GEN_STEP;
                  end
                  OP_SEED: begin
                     if (pop_cmd.seed_first) pos_in = '0;
                     if (n != '0) begin
                        state_in = ST_SEED;
                        d_in     = NW'(seed_start);
                        r_in     = rd_acc;
                        mod_in   = rd_mod;
                        sh_in    = {pop_cmd.seed_byte, {(W-SEED_BITS){1'b0}}};
                        cnt_in   = CW'(SEED_BITS);
                     end
                  end
                  default: begin
                     if (n != '0) state_in = ST_MIDDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            r_in   = W'(trial);
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               tab_we   = 1'b1;
               acc_we   = 1'b1;
               acc_wa   = DW'(cmd_ff.dim);
               acc_wd   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_GEN_STEP: begin
            acc_we   = 1'b1;
            acc_wd   = gen_acc;
            r_in     = gen_acc;
            mod_in   = rd_mod;
            state_in = ST_GEN_EMIT;
         end
         ST_GEN_EMIT: begin
            if (slot_free) begin
               out_load = 1'b1;
               d_in     = d_ff + NW'(1);
               state_in = (d_ff + NW'(1) == n) ? ST_IDLE : ST_GEN_STEP;
            end
         end
         ST_SEED: begin
            r_in   = W'(trial);
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               acc_we   = 1'b1;
               acc_wd   = (mod_ff == '0) ? '0 : W'(trial);
               pos_in   = DW'(pos_next);
               state_in = ST_IDLE;
            end
         end
         ST_MIDDLE: begin
            acc_we = 1'b1;
            acc_wd = rd_mod >> 1;
            d_in   = d_ff + NW'(1);
            if (d_ff + NW'(1) == n) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_vld_in = out_load || (out_vld_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         acc_vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         out_vld_ff <= out_vld_in;
         if (acc_we) acc_vld_ff[acc_wa] <= 1'b1;
      end
      cmd_ff <= cmd_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      sh_ff  <= sh_in;
      mod_ff <= mod_in;
      if (acc_we) acc_tab[acc_wa] <= acc_wd;
      if (tab_we) begin
         step_tab[DW'(cmd_ff.dim)] <= W'(trial);
         mod_tab[DW'(cmd_ff.dim)]  <= mod_ff;
      end
      if (out_load) begin
         out_dim_ff  <= 4'(d_ff);
         out_num_ff  <= {scr, 1'b1};
         out_den_ff  <= {mod_ff, 1'b0};
         out_last_ff <= (d_ff + NW'(1) == n);
      end
   end

   assign rsp.valid             = out_vld_ff;
   assign rsp.dim_out           = out_dim_ff;
   assign rsp.point_numerator   = out_num_ff;
   assign rsp.point_denominator = out_den_ff;
   assign rsp.last              = out_last_ff;
endmodule

### src/richtmyer_sequence_generator_core.sv
// ----------------------------------------------------------------------------
// richtmyer_sequence_generator_core
// Scrambled Richtmyer sequence generator with a register port.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer
//  req_ch   in         one command item (load, generate, seed, middle)
//  rsp_ch   out        one coordinate of a point, last flags the final one
//  csr_*    in/out     APB register writes and reads
//
// Every item passes through the front register, the queue and a dispatch
// step in the sequencer before its work starts. A generate item then works
// through each dimension in use with a modular add, then a scramble into the
// output register. A load reduces the step by shift-subtract over its
// VALUE_WIDTH bits; a seed byte goes through the same shift-subtract over its
// eight bits; a middle item visits each dimension in use.
// Reset is synchronous; no clearing pass is needed. A stalled result holds
// the sequencer, while the front register and queue keep taking items until
// all three slots are full.
module richtmyer_sequence_generator_core #(
   parameter int MAX_DIMS    = 16,
   parameter int VALUE_WIDTH = 48
) (
   input  logic        clock,
   input  logic        reset,
   rsg_req_if.sink     req_ch,
   rsg_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rsg_pkg::*;

   logic [4:0]             dims_ff;
   scramble_type           mode_ff;
   logic                   push, push_ready, pop_valid, pop;
   cmd_type                push_cmd, pop_cmd;
   logic [VALUE_WIDTH-1:0] push_step, push_mod, pop_step, pop_mod;

   // Register port.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
         mode_ff <= SCR_NONE;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            CSR_DIMS: dims_ff <= csr_pwdata[4:0];
            default:  mode_ff <= scramble_type'(csr_pwdata[1:0]);
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_DIMS: csr_prdata = {27'd0, dims_ff};
         default:  csr_prdata = {30'd0, mode_ff};
      endcase
   end

   rsg_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock(clock), .reset(reset), .req(req_ch),
      .push(push), .push_ready(push_ready), .push_cmd(push_cmd),
      .push_step(push_step), .push_mod(push_mod)
   );

   rsg_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_ready(push_ready), .push_cmd(push_cmd),
      .push_step(push_step), .push_mod(push_mod),
      .pop_valid(pop_valid), .pop(pop), .pop_cmd(pop_cmd),
      .pop_step(pop_step), .pop_mod(pop_mod)
   );

   rsg_back #(.MAX_DIMS(MAX_DIMS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock(clock), .reset(reset), .cfg_dims(dims_ff), .cfg_mode(mode_ff),
      .pop_valid(pop_valid), .pop(pop), .pop_cmd(pop_cmd),
      .pop_step(pop_step), .pop_mod(pop_mod), .rsp(rsp_ch)
   );
endmodule
